@@ sv/rec_pkg.sv @@
`default_nettype none

package rec_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_A_CHANGE = 3'd1,
    OP_BUTTON   = 3'd2,
    OP_READ_POS = 3'd3,
    OP_READ_BTN = 3'd4
  } op_t;

  localparam logic [1:0] BTN_OPEN    = 2'd0;
  localparam logic [1:0] BTN_PRESSED = 2'd1;
  localparam logic [1:0] BTN_HELD    = 2'd2;
  localparam logic [1:0] BTN_CLICKED = 2'd3;

  localparam logic [16:0] TICK_MAX         = 17'h1FFFF;
  localparam logic [15:0] HOLD_LIMIT_RESET = 16'd1000;

  typedef struct packed {
    logic [2:0] op;
    logic       level_a;
    logic       level_b;
    logic       level_button;
  } item_t;

  typedef struct packed {
    logic signed [15:0] position;
    logic [1:0]         button_state;
  } result_t;

endpackage

`default_nettype wire

@@ sv/rotary_encoder_with_click_hold.sv @@
// Channel  Handshake          Payload
// in       in_valid/in_stall  op, level_a, level_b, level_button
// out      out_valid/out_stall position, button_state
// cfg      cfg_valid/cfg_ready hold_limit
//
// One item is accepted per cycle while in_stall is low; a read result passes through the input register
// and then the output register. The state registers update when an item leaves the input register.
// Reset is synchronous and clears the valid flags and the encoder state; hold_limit returns to 1000.
// A stalled result holds the output register, and in_stall rises only when a read waits on it.
// Configuration writes are always taken.
`default_nettype none

module rotary_encoder_with_click_hold
  import rec_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         op,
  input  wire logic               level_a,
  input  wire logic               level_b,
  input  wire logic               level_button,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      position,
  output logic [1:0]              button_state,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        hold_limit
);

  logic [15:0] hold_limit_reg;
  item_t       in_item;
  item_t       s1_item;
  logic        s1_valid;
  logic        advance;
  logic        out_ready;
  logic        res_load;
  result_t     res;
  result_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_limit_reg <= HOLD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      hold_limit_reg <= hold_limit;
    end
  end

  assign in_item.op           = op;
  assign in_item.level_a      = level_a;
  assign in_item.level_b      = level_b;
  assign in_item.level_button = level_button;

  rec_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_item  (in_item),
    .advance  (advance),
    .in_stall (in_stall),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  rec_core u_core (
    .clk        (clk),
    .rst        (rst),
    .s1_valid   (s1_valid),
    .s1_item    (s1_item),
    .out_ready  (out_ready),
    .hold_limit (hold_limit_reg),
    .advance    (advance),
    .res_load   (res_load),
    .res        (res)
  );

  rec_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_stall (out_stall),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign position     = out_res.position;
  assign button_state = out_res.button_state;

endmodule

`default_nettype wire

@@ sv/rec_in_stage.sv @@
`default_nettype none

module rec_in_stage
  import rec_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire item_t in_item,
  input  wire logic  advance,
  output logic       in_stall,
  output logic       s1_valid,
  output item_t      s1_item
);

  logic accept;

  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ sv/rec_core.sv @@
`default_nettype none

module rec_core
  import rec_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s1_valid,
  input  wire item_t       s1_item,
  input  wire logic        out_ready,
  input  wire logic [15:0] hold_limit,
  output logic             advance,
  output logic             res_load,
  output result_t          res
);

  logic [15:0] step_count;
  logic [15:0] step_count_next;
  logic [1:0]  button_code;
  logic [1:0]  button_code_next;
  logic [16:0] down_ticks;
  logic [16:0] down_ticks_next;
  logic        has_result;
  logic        fire;
  op_t         op;

  assign op         = op_t'(s1_item.op);
  assign has_result = (op == OP_READ_POS) || (op == OP_READ_BTN);
  assign advance    = s1_valid && (!has_result || out_ready);
  assign fire       = advance;
  assign res_load   = fire && has_result;

  always_comb begin
    step_count_next  = step_count;
    button_code_next = button_code;
    down_ticks_next  = down_ticks;
    res.position     = 16'sd0;
    res.button_state = BTN_OPEN;
    case (op)
      OP_TICK: begin
        if (down_ticks != TICK_MAX) begin
          down_ticks_next = down_ticks + 17'd1;
        end
      end
      OP_A_CHANGE: begin
        if (s1_item.level_a == s1_item.level_b) begin
          step_count_next = step_count + 16'd1;
        end else begin
          step_count_next = step_count - 16'd1;
        end
      end
      OP_BUTTON: begin
        if (!s1_item.level_button) begin
          button_code_next = BTN_PRESSED;
          down_ticks_next  = 17'd0;
        end else if (down_ticks > {1'b0, hold_limit}) begin
          button_code_next = BTN_HELD;
        end else begin
          button_code_next = BTN_CLICKED;
        end
      end
      OP_READ_POS: begin
        res.position    = $signed(step_count);
        step_count_next = 16'd0;
      end
      OP_READ_BTN: begin
        res.button_state = button_code;
        button_code_next = BTN_OPEN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= 16'd0;
      button_code <= BTN_OPEN;
      down_ticks  <= 17'd0;
    end else if (fire) begin
      step_count  <= step_count_next;
      button_code <= button_code_next;
      down_ticks  <= down_ticks_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/rec_out_reg.sv @@
`default_nettype none

module rec_out_reg
  import rec_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    res_load,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         out_ready,
  output logic         out_valid,
  output result_t      out_res
);

  assign out_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

@@ sv/rec_checker.sv @@
`default_nettype none

module rec_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] position,
  input wire logic [1:0]  button_state
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(position) && $stable(button_state))
    else $error("result payload changed while stalled");

  // A result carries either a position or a button state, never both.
  a_one_field: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (position == 16'd0 || button_state == 2'd0))
    else $error("result carries both position and button state");

  // The input stalls only behind a result beat that is itself stalled.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no stalled result beat");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind rotary_encoder_with_click_hold rec_checker u_rec_checker (
  .clk          (clk),
  .rst          (rst),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .position     (position),
  .button_state (button_state)
);

`default_nettype wire

@@ tb/sv/rotary_encoder_with_click_hold_test.sv @@
`timescale 1ns / 1ps

module rotary_encoder_with_click_hold_test;
  import rec_pkg::*;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = OP_TICK;
  logic level_a = 1'b0;
  logic level_b = 1'b0;
  logic level_button = 1'b1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] position;
  logic [1:0] button_state;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] hold_limit = 16'd0;

  rotary_encoder_with_click_hold u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .level_a(level_a),
    .level_b(level_b),
    .level_button(level_button),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .position(position),
    .button_state(button_state),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .hold_limit(hold_limit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected behavior of the encoder, updated on every accepted input beat.
  logic [15:0] hold_setting = HOLD_LIMIT_RESET;
  logic [15:0] step_model = 16'd0;
  logic [1:0] button_model = BTN_OPEN;
  logic [16:0] down_ticks_model = 17'd0;

  item_t pending_beats[$];
  result_t expected_results[$];
  item_t offered;

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int useful_cnt = 0;
  int results_checked = 0;
  int held_seen = 0;
  int clicked_seen = 0;
  int long_holds = 0;
  int cfg_writes = 0;
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit steady = 1'b0;
  int rx_cycle = 0;
  int hold_off_left = 0;
  result_t want;

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void apply_beat(item_t b);
    result_t r;
    case (b.op)
      OP_TICK: begin
        if (down_ticks_model < TICK_MAX) down_ticks_model = down_ticks_model + 17'd1;
      end
      OP_A_CHANGE: begin
        if (b.level_a == b.level_b) step_model = step_model + 16'd1;
        else step_model = step_model - 16'd1;
      end
      OP_BUTTON: begin
        if (!b.level_button) begin
          button_model = BTN_PRESSED;
          down_ticks_model = 17'd0;
        end else if (down_ticks_model > {1'b0, hold_setting}) begin
          button_model = BTN_HELD;
        end else begin
          button_model = BTN_CLICKED;
        end
      end
      OP_READ_POS: begin
        r.position = step_model;
        r.button_state = BTN_OPEN;
        expected_results.push_back(r);
        step_model = 16'd0;
      end
      OP_READ_BTN: begin
        r.position = 16'sd0;
        r.button_state = button_model;
        expected_results.push_back(r);
        button_model = BTN_OPEN;
      end
      default: ;
    endcase
  endfunction

  function automatic void add_item(logic [2:0] o, logic a, logic b, logic btn);
    item_t it;
    it.op = o;
    it.level_a = a;
    it.level_b = b;
    it.level_button = btn;
    pending_beats.push_back(it);
    queued_cnt++;
    if (o <= OP_READ_BTN) useful_cnt++;
  endfunction

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_beat(offered);
        accepted_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          offered = pending_beats.pop_front();
          op <= offered.op;
          level_a <= offered.level_a;
          level_b <= offered.level_b;
          level_button <= offered.level_button;
          in_valid <= 1'b1;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (steady || $urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side stall pattern, with a recurring long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      rx_cycle <= 0;
      hold_off_left <= 0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (hold_off_left != 0) begin
        hold_off_left <= hold_off_left - 1;
        out_stall <= 1'b1;
      end else if (rx_cycle % 2500 == 1200) begin
        hold_off_left <= 300;
        long_holds++;
        out_stall <= 1'b1;
      end else begin
        case ((rx_cycle / 64) % 6)
          0, 1: out_stall <= 1'b0;
          2: out_stall <= rand_bit();
          3: out_stall <= (rx_cycle % 3 == 0);
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: position %0d button_state %0d",
               position, button_state);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, position);
          errors++;
        end
        if (button_state !== want.button_state) begin
          $error("button_state: expected %0d, actual %0d", want.button_state, button_state);
          errors++;
        end
        if (want.button_state == BTN_HELD) held_seen++;
        if (want.button_state == BTN_CLICKED) clicked_seen++;
      end
    end
  end

  task automatic write_hold(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    hold_limit <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hold_setting = v;
    cfg_writes++;
  endtask

  task automatic wait_idle(input int limit);
    int n;
    n = 0;
    while ((accepted_cnt != queued_cnt || expected_results.size() != 0) && n < limit) begin
      @(posedge clk);
      n++;
    end
    if (n >= limit) begin
      $error("results still missing after %0d cycles: %0d", limit, expected_results.size());
      errors++;
      expected_results.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic press_ticks_release(input int ticks);
    add_item(OP_BUTTON, rand_bit(), rand_bit(), 1'b0);
    repeat (ticks) add_item(OP_TICK, rand_bit(), rand_bit(), rand_bit());
    add_item(OP_BUTTON, rand_bit(), rand_bit(), 1'b1);
    add_item(OP_READ_BTN, rand_bit(), rand_bit(), rand_bit());
  endtask

  task automatic random_phase(input int target);
    int start;
    int k;
    int r;
    logic [2:0] o;
    start = useful_cnt;
    while (useful_cnt - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // Press, a tick count near the threshold (at most 12 for a large one), then release; sometimes broken off.
        add_item(OP_BUTTON, rand_bit(), rand_bit(), 1'b0);
        if (hold_setting < 64) k = $urandom_range(0, hold_setting + 3);
        else k = $urandom_range(0, 12);
        repeat (k) begin
          if ($urandom_range(0, 9) == 0) add_item(OP_A_CHANGE, rand_bit(), rand_bit(), rand_bit());
          add_item(OP_TICK, rand_bit(), rand_bit(), rand_bit());
        end
        if ($urandom_range(0, 9) != 0) add_item(OP_BUTTON, rand_bit(), rand_bit(), 1'b1);
        if ($urandom_range(0, 4) != 0) add_item(OP_READ_BTN, rand_bit(), rand_bit(), rand_bit());
      end else if (r < 50) begin
        repeat ($urandom_range(1, 10)) add_item(OP_A_CHANGE, rand_bit(), rand_bit(), rand_bit());
        if ($urandom_range(0, 4) != 0) add_item(OP_READ_POS, rand_bit(), rand_bit(), rand_bit());
      end else begin
        o = 3'($urandom_range(0, 7));
        add_item(o, rand_bit(), rand_bit(), rand_bit());
      end
    end
    wait_idle(100000);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, every direction of a step, button presses and clicks, and the unused op codes.
    add_item(OP_READ_POS, 1'b0, 1'b0, 1'b0);
    add_item(OP_READ_BTN, 1'b1, 1'b1, 1'b1);
    add_item(OP_A_CHANGE, 1'b0, 1'b0, 1'b1);
    add_item(OP_A_CHANGE, 1'b1, 1'b1, 1'b0);
    add_item(OP_A_CHANGE, 1'b0, 1'b1, 1'b1);
    add_item(OP_A_CHANGE, 1'b1, 1'b0, 1'b0);
    add_item(OP_A_CHANGE, 1'b1, 1'b0, 1'b1);
    add_item(OP_READ_POS, 1'b1, 1'b0, 1'b1);
    add_item(OP_READ_POS, 1'b0, 1'b1, 1'b0);
    add_item(OP_BUTTON, 1'b1, 1'b1, 1'b1);
    add_item(OP_READ_BTN, 1'b0, 1'b0, 1'b0);
    add_item(OP_BUTTON, 1'b1, 1'b1, 1'b0);
    add_item(OP_READ_BTN, 1'b0, 1'b0, 1'b1);
    add_item(OP_READ_BTN, 1'b0, 1'b0, 1'b1);
    add_item(OP_BUTTON, 1'b0, 1'b0, 1'b0);
    add_item(OP_TICK, 1'b1, 1'b1, 1'b1);
    add_item(OP_BUTTON, 1'b0, 1'b1, 1'b0);
    add_item(OP_BUTTON, 1'b1, 1'b0, 1'b1);
    add_item(OP_READ_BTN, 1'b0, 1'b0, 1'b0);
    add_item(OP_SPARE_5, 1'b1, 1'b1, 1'b1);
    add_item(OP_SPARE_6, 1'b0, 1'b1, 1'b0);
    add_item(OP_SPARE_7, 1'b1, 1'b0, 1'b1);
    add_item(OP_READ_POS, 1'b1, 1'b1, 1'b1);
    wait_idle(10000);

    // Release exactly at the threshold is a click; one tick more is a hold.
    write_hold(16'd3);
    press_ticks_release(3);
    press_ticks_release(4);
    wait_idle(10000);

    write_hold(16'd0);
    press_ticks_release(0);
    press_ticks_release(1);
    wait_idle(10000);

    // A press against the largest setting is a click, and steps below zero give a
    // negative position.
    write_hold(16'hFFFF);
    steady = 1'b1;
    press_ticks_release(20);
    repeat (40) add_item(OP_A_CHANGE, 1'b0, 1'b1, rand_bit());
    add_item(OP_READ_POS, rand_bit(), rand_bit(), rand_bit());
    wait_idle(10000);
    steady = 1'b0;

    write_hold(16'($urandom_range(0, 15)));
    random_phase(390);
    write_hold(16'hFFFF);
    random_phase(390);
    write_hold(16'h0000);
    random_phase(390);
    write_hold(16'($urandom_range(1, 40)));
    random_phase(390);

    $display("Run covered %0d input beats, %0d result beats (%0d held, %0d clicked),",
             accepted_cnt, results_checked, held_seen, clicked_seen);
    $display("%0d hold limit writes and %0d long result hold-offs.", cfg_writes, long_holds);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
sv/rec_pkg.sv
sv/rec_in_stage.sv
sv/rec_core.sv
sv/rec_out_reg.sv
sv/rotary_encoder_with_click_hold.sv
sv/rec_checker.sv
tb/sv/rotary_encoder_with_click_hold_test.sv
